FILE: rtl/core/rcbd_pkg.sv
// Shared constants and types for the byte-chained RSA decryption block.
// No dependencies.
`timescale 1ns / 1ps

package rcbd_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = $clog2(KEY_W);
    localparam int unsigned IDX_W   = 1;
    localparam int unsigned TDATA_W = ((KEY_W + BYTE_W + 7) / 8) * 8;

    localparam logic [KEY_W-1:0] EXP_RESET = KEY_W'(16971);
    localparam logic [KEY_W-1:0] MOD_RESET = KEY_W'(25777);
    localparam logic [KEY_W-1:0] KEY_ONE   = KEY_W'(1);
    localparam logic [CNT_W-1:0] CNT_LAST  = {CNT_W{1'b1}};

    typedef enum logic [IDX_W-1:0] {
        CFG_EXPONENT = 1'b0,
        CFG_MODULUS  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        MODE_NONCE = 1'b0,
        MODE_BLOCK = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EXP,
        ST_MUL,
        ST_SQR,
        ST_FIN
    } t_state;

endpackage

FILE: rtl/core/rsa_cbc_byte_decrypt.sv
// Byte-chained RSA decryption: serial modular exponentiation and chaining.
// Depends on rcbd_pkg.
`timescale 1ns / 1ps

// One word in, one word out. The ciphertext is first reduced modulo the modulus
// one bit per cycle. Then each of the 32 exponent bits, taken from the least
// significant up, costs a dispatch state, a modular multiply when the bit is
// set, and a modular square, all on a single bit-serial shift-and-add
// multiplier with a 2r+a conditional-subtract step. The finished word waits in
// the final state until the output register is empty or being read. One item
// is in work at a time; a finished word waits in the output register while the
// next word is accepted. A modulus of zero skips reduction and wraps products
// to 32 bits; an exponent of zero gives 1.
module rsa_cbc_byte_decrypt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rcbd_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [rcbd_pkg::KEY_W-1:0]   i_cfg_data,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [rcbd_pkg::KEY_W-1:0]   i_s_tdata,   // [31:0] cipher_value
    input  logic                         i_s_tuser,   // [0] mode
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [rcbd_pkg::TDATA_W-1:0] o_m_tdata,   // [31:0] decrypted_value, [39:32] plain_byte
    output logic                         o_m_tuser    // [0] was_nonce
);
    import rcbd_pkg::*;

    t_state                 r_state, n_state;
    logic [KEY_W-1:0]       r_exp, r_mod;
    logic [BYTE_W-1:0]      r_chain, n_chain;
    logic                   r_out_valid, n_out_valid;
    logic [TDATA_W-1:0]     r_out_data, n_out_data;
    logic                   r_out_user, n_out_user;

    logic                   r_mode, n_mode;
    logic [BYTE_W-1:0]      r_clow, n_clow;
    logic                   r_ezero, n_ezero;
    logic [KEY_W-1:0]       r_e, n_e;
    logic [CNT_W-1:0]       r_ecnt, n_ecnt;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [KEY_W-1:0]       r_base, n_base;
    logic [KEY_W-1:0]       r_res, n_res;
    logic [KEY_W-1:0]       r_acc, n_acc;
    logic [KEY_W-1:0]       r_bsh, n_bsh;
    logic [KEY_W-1:0]       r_mcand, n_mcand;

    logic                   w_accept;
    logic                   w_mod_zero;
    logic [KEY_W:0]         w_rsh;
    logic [KEY_W+1:0]       w_rsub;
    logic [KEY_W+1:0]       w_t;
    logic [KEY_W+2:0]       w_d1, w_d2;
    logic [KEY_W-1:0]       w_step;
    logic [KEY_W-1:0]       w_dec;
    logic [BYTE_W-1:0]      w_low;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_mod_zero = (r_mod == '0);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // restoring remainder step for the ciphertext
    assign w_rsh  = {r_acc, r_bsh[KEY_W-1]};
    assign w_rsub = {1'b0, w_rsh} - {2'b00, r_mod};

    // shift-and-add modular step: 2r + b*a, minus m or 2m
    assign w_t  = {1'b0, r_acc, 1'b0} + {2'b00, (r_bsh[KEY_W-1] ? r_mcand : '0)};
    assign w_d1 = {1'b0, w_t} - {3'b000, r_mod};
    assign w_d2 = {1'b0, w_t} - {2'b00, r_mod, 1'b0};

    always_comb begin
        if (w_mod_zero) begin
            w_step = w_t[KEY_W-1:0];
        end else if (!w_d2[KEY_W+2]) begin
            w_step = w_d2[KEY_W-1:0];
        end else if (!w_d1[KEY_W+2]) begin
            w_step = w_d1[KEY_W-1:0];
        end else begin
            w_step = w_t[KEY_W-1:0];
        end
    end

    assign w_dec = r_ezero ? KEY_ONE : r_res;
    assign w_low = w_dec[BYTE_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_chain     = r_chain;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_mode      = r_mode;
        n_clow      = r_clow;
        n_ezero     = r_ezero;
        n_e         = r_e;
        n_ecnt      = r_ecnt;
        n_cnt       = r_cnt;
        n_base      = r_base;
        n_res       = r_res;
        n_acc       = r_acc;
        n_bsh       = r_bsh;
        n_mcand     = r_mcand;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_mode  = i_s_tuser;
                    n_clow  = i_s_tdata[BYTE_W-1:0];
                    n_ezero = (r_exp == '0);
                    n_e     = r_exp;
                    n_ecnt  = '0;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_bsh   = i_s_tdata;
                    n_base  = i_s_tdata;
                    n_res   = (r_mod == KEY_ONE) ? '0 : KEY_ONE;
                    n_state = w_mod_zero ? ST_EXP : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                n_acc = w_rsub[KEY_W+1] ? w_rsh[KEY_W-1:0] : w_rsub[KEY_W-1:0];
                n_bsh = {r_bsh[KEY_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_base  = n_acc;
                    n_state = ST_EXP;
                end
            end
            ST_EXP: begin
                n_acc   = '0;
                n_cnt   = '0;
                n_bsh   = r_base;
                n_mcand = r_e[0] ? r_res : r_base;
                n_state = r_e[0] ? ST_MUL : ST_SQR;
            end
            ST_MUL: begin
                n_acc = w_step;
                n_bsh = {r_bsh[KEY_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_res   = w_step;
                    n_acc   = '0;
                    n_bsh   = r_base;
                    n_mcand = r_base;
                    n_state = ST_SQR;
                end
            end
            ST_SQR: begin
                n_acc = w_step;
                n_bsh = {r_bsh[KEY_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_base  = w_step;
                    n_e     = {1'b0, r_e[KEY_W-1:1]};
                    n_ecnt  = r_ecnt + 1'b1;
                    n_state = (r_ecnt == CNT_LAST) ? ST_FIN : ST_EXP;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b0;
                    if (r_mode == MODE_NONCE) begin
                        n_out_data = TDATA_W'({w_low, w_dec});
                        n_out_user = 1'b1;
                        n_chain    = w_low;
                    end else begin
                        n_out_data = TDATA_W'({w_low ^ r_chain, w_dec});
                        n_out_user = 1'b0;
                        n_chain    = r_clow;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_exp       <= EXP_RESET;
            r_mod       <= MOD_RESET;
            r_chain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_EXPONENT: r_exp <= i_cfg_data;
                    CFG_MODULUS:  r_mod <= i_cfg_data;
                    default:      r_exp <= r_exp;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_mode     <= n_mode;
        r_clow     <= n_clow;
        r_ezero    <= n_ezero;
        r_e        <= n_e;
        r_ecnt     <= n_ecnt;
        r_cnt      <= n_cnt;
        r_base     <= n_base;
        r_res      <= n_res;
        r_acc      <= n_acc;
        r_bsh      <= n_bsh;
        r_mcand    <= n_mcand;
    end

endmodule
